FILE: rtl/core/bfa_pkg.sv
`timescale 1ns / 1ps

package bfa_pkg;

   // bitmap geometry
   localparam int BITMAP_ENTRIES = 32768;
   localparam int WORD_BITS      = 32;
   localparam int NUM_WORDS      = BITMAP_ENTRIES / WORD_BITS;
   localparam int WORD_AW        = $clog2(NUM_WORDS);
   localparam int BIT_AW         = $clog2(WORD_BITS);

   // field widths
   localparam int OP_W     = 2;
   localparam int INDEX_W  = 15;
   localparam int LIMIT_W  = 16;
   localparam int OFFSET_W = 32;
   localparam int CSR_DW   = 32;
   localparam int CSR_AW   = 3;

   // reset values of the registers
   localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = LIMIT_W'(32768);
   localparam logic [OFFSET_W-1:0] OFFSET_RESET = '0;

   // operation codes (code 3 behaves as a test)
   localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
   localparam logic [OP_W-1:0] OP_TEST  = 2'd1;
   localparam logic [OP_W-1:0] OP_MARK  = 2'd2;

   // register select, taken from paddr[2]
   localparam logic REG_SEARCH_LIMIT = 1'b0;
   localparam logic REG_BASE_OFFSET  = 1'b1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_ACCESS
   } state_type;

   typedef struct packed {
      logic              found;
      logic [BIT_AW-1:0] pos;
   } free_bit_type;

   // lowest clear bit of one bitmap word
   function automatic free_bit_type first_free(input logic [WORD_BITS-1:0] word);
      free_bit_type res;
      res.found = 1'b0;
      res.pos   = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!word[i]) begin
            res.found = 1'b1;
            res.pos   = BIT_AW'(i);
         end
      end
      return res;
   endfunction

endpackage

FILE: rtl/core/bitmap_first_free_allocator.sv
`timescale 1ns / 1ps

// test and mark read the addressed word, then register the result; allocate scans
// the words in order, at most all 1024, paced by the one-word-a-cycle
// read port of the bitmap ram and the single priority encoder behind it.
// throughput: one request at a time; busy stays high until the request is done.
// reset: a clearing pass writes all 1024 bitmap words to zero (busy meanwhile).
// results appear on a one-cycle strobe and the receiver cannot stall them.
module bitmap_first_free_allocator (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          start,
   output logic                          busy,
   input  logic [bfa_pkg::OP_W-1:0]      req_operation,
   input  logic [bfa_pkg::INDEX_W-1:0]   req_entry_index,
   // result channel
   output logic                          rsp_strobe,
   output logic                          rsp_success,
   output logic [bfa_pkg::INDEX_W-1:0]   rsp_found_index,
   output logic [bfa_pkg::OFFSET_W-1:0]  rsp_absolute_number,
   output logic                          rsp_bit_value,
   // register port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [bfa_pkg::CSR_AW-1:0]    paddr,
   input  logic [bfa_pkg::CSR_DW-1:0]    pwdata,
   output logic [bfa_pkg::CSR_DW-1:0]    prdata,
   output logic                          pready
);

   localparam logic [bfa_pkg::WORD_AW-1:0] LAST_WORD = bfa_pkg::WORD_AW'(bfa_pkg::NUM_WORDS - 1);

   bfa_pkg::state_type              state_ff, state_in;
   logic [bfa_pkg::WORD_AW-1:0]     addr_ff, addr_in;
   logic [bfa_pkg::WORD_AW-1:0]     chk_ff, chk_in;
   logic [bfa_pkg::OP_W-1:0]        op_ff, op_in;
   logic [bfa_pkg::INDEX_W-1:0]     idx_ff, idx_in;
   logic [bfa_pkg::LIMIT_W-1:0]     limit_ff;
   logic [bfa_pkg::OFFSET_W-1:0]    offset_ff;

   logic                            rsp_strobe_ff, rsp_strobe_in;
   logic                            rsp_success_ff, rsp_success_in;
   logic [bfa_pkg::INDEX_W-1:0]     rsp_found_index_ff, rsp_found_index_in;
   logic [bfa_pkg::OFFSET_W-1:0]    rsp_absolute_number_ff, rsp_absolute_number_in;
   logic                            rsp_bit_value_ff, rsp_bit_value_in;

   logic                            ram_wr_en;
   logic [bfa_pkg::WORD_AW-1:0]     ram_wr_addr;
   logic [bfa_pkg::WORD_BITS-1:0]   ram_wr_data;
   logic [bfa_pkg::WORD_AW-1:0]     ram_rd_addr;
   logic [bfa_pkg::WORD_BITS-1:0]   ram_rd_data;

   logic                            accept;
   logic                            csr_write;
   bfa_pkg::free_bit_type           free_bit;
   logic [bfa_pkg::INDEX_W-1:0]     scan_index;

   assign busy      = (state_ff != bfa_pkg::ST_IDLE);
   assign accept    = start && !busy;
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   // register port
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff  <= bfa_pkg::LIMIT_RESET;
         offset_ff <= bfa_pkg::OFFSET_RESET;
      end else if (csr_write) begin
         if (paddr[2] == bfa_pkg::REG_BASE_OFFSET) begin
            offset_ff <= pwdata;
         end else begin
            limit_ff <= pwdata[bfa_pkg::LIMIT_W-1:0];
         end
      end
   end

   assign prdata = (paddr[2] == bfa_pkg::REG_SEARCH_LIMIT)
                 ? bfa_pkg::CSR_DW'(limit_ff) : offset_ff;

   // bitmap storage
   bfa_ram #(
      .WIDTH (bfa_pkg::WORD_BITS),
      .DEPTH (bfa_pkg::NUM_WORDS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // priority encoder on the word just read, used by the allocation scan
   assign free_bit   = bfa_pkg::first_free(ram_rd_data);
   assign scan_index = {chk_ff, free_bit.pos};

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bfa_pkg::ST_CLEAR;
         addr_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         addr_ff       <= addr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      chk_ff                 <= chk_in;
      op_ff                  <= op_in;
      idx_ff                 <= idx_in;
      rsp_success_ff         <= rsp_success_in;
      rsp_found_index_ff     <= rsp_found_index_in;
      rsp_absolute_number_ff <= rsp_absolute_number_in;
      rsp_bit_value_ff       <= rsp_bit_value_in;
   end

   // sequencer
   always_comb begin
      logic bit_now;
      state_in               = state_ff;
      addr_in                = addr_ff;
      chk_in                 = chk_ff;
      op_in                  = op_ff;
      idx_in                 = idx_ff;
      rsp_strobe_in          = 1'b0;
      rsp_success_in         = rsp_success_ff;
      rsp_found_index_in     = rsp_found_index_ff;
      rsp_absolute_number_in = rsp_absolute_number_ff;
      rsp_bit_value_in       = rsp_bit_value_ff;
      ram_wr_en              = 1'b0;
      ram_wr_addr            = addr_ff;
      ram_wr_data            = '0;
      ram_rd_addr            = addr_ff;
      bit_now                = ram_rd_data[idx_ff[bfa_pkg::BIT_AW-1:0]];

      case (state_ff)
         // zero the bitmap word by word after reset
         bfa_pkg::ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = addr_ff;
            ram_wr_data = '0;
            addr_in     = addr_ff + bfa_pkg::WORD_AW'(1);
            if (addr_ff == LAST_WORD) begin
               state_in = bfa_pkg::ST_IDLE;
            end
         end

         // take a request and issue its first read
         bfa_pkg::ST_IDLE: begin
            if (accept) begin
               op_in  = req_operation;
               idx_in = req_entry_index;
               if (req_operation == bfa_pkg::OP_ALLOC) begin
                  ram_rd_addr = '0;
                  addr_in     = bfa_pkg::WORD_AW'(1);
                  chk_in      = '0;
                  state_in    = bfa_pkg::ST_SCAN;
               end else begin
                  ram_rd_addr = req_entry_index[bfa_pkg::INDEX_W-1:bfa_pkg::BIT_AW];
                  state_in    = bfa_pkg::ST_ACCESS;
               end
            end
         end

         // stream words through the encoder, checking one read behind
         bfa_pkg::ST_SCAN: begin
            ram_rd_addr = addr_ff;
            chk_in      = addr_ff;
            addr_in     = addr_ff + bfa_pkg::WORD_AW'(1);
            if ({1'b0, chk_ff, bfa_pkg::BIT_AW'(0)} >= limit_ff) begin
               // whole word lies past the search limit
               rsp_strobe_in          = 1'b1;
               rsp_success_in         = 1'b0;
               rsp_found_index_in     = '0;
               rsp_absolute_number_in = '0;
               rsp_bit_value_in       = 1'b0;
               state_in               = bfa_pkg::ST_IDLE;
            end else if (free_bit.found) begin
               rsp_strobe_in    = 1'b1;
               rsp_bit_value_in = 1'b0;
               state_in         = bfa_pkg::ST_IDLE;
               if ({1'b0, scan_index} < limit_ff) begin
                  ram_wr_en              = 1'b1;
                  ram_wr_addr            = chk_ff;
                  ram_wr_data            = ram_rd_data
                                         | (bfa_pkg::WORD_BITS'(1) << free_bit.pos);
                  rsp_success_in         = 1'b1;
                  rsp_found_index_in     = scan_index;
                  rsp_absolute_number_in = offset_ff + bfa_pkg::OFFSET_W'(scan_index);
               end else begin
                  rsp_success_in         = 1'b0;
                  rsp_found_index_in     = '0;
                  rsp_absolute_number_in = '0;
               end
            end else if (chk_ff == LAST_WORD) begin
               // bitmap full
               rsp_strobe_in          = 1'b1;
               rsp_success_in         = 1'b0;
               rsp_found_index_in     = '0;
               rsp_absolute_number_in = '0;
               rsp_bit_value_in       = 1'b0;
               state_in               = bfa_pkg::ST_IDLE;
            end
         end

         // test or mark on the word just read
         bfa_pkg::ST_ACCESS: begin
            rsp_strobe_in          = 1'b1;
            rsp_success_in         = 1'b1;
            rsp_found_index_in     = idx_ff;
            rsp_absolute_number_in = offset_ff + bfa_pkg::OFFSET_W'(idx_ff);
            rsp_bit_value_in       = bit_now;
            if (op_ff == bfa_pkg::OP_MARK) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = idx_ff[bfa_pkg::INDEX_W-1:bfa_pkg::BIT_AW];
               ram_wr_data = ram_rd_data
                           | (bfa_pkg::WORD_BITS'(1) << idx_ff[bfa_pkg::BIT_AW-1:0]);
            end
            state_in = bfa_pkg::ST_IDLE;
         end

         default: begin
            state_in = bfa_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_success         = rsp_success_ff;
   assign rsp_found_index     = rsp_found_index_ff;
   assign rsp_absolute_number = rsp_absolute_number_ff;
   assign rsp_bit_value       = rsp_bit_value_ff;

   // a result only follows a scan or access cycle
   a_strobe_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> ($past(state_ff) == bfa_pkg::ST_SCAN
                      || $past(state_ff) == bfa_pkg::ST_ACCESS))
      else $error("result strobe without a finishing request");

   // failed allocation reports zero fields
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && !rsp_success_ff |-> rsp_found_index_ff == '0
                                         && rsp_absolute_number_ff == '0
                                         && !rsp_bit_value_ff)
      else $error("failed allocation with nonzero fields");

   // successful allocation stays below the search limit and was free
   a_alloc_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_success_ff && op_ff == bfa_pkg::OP_ALLOC
      |-> {1'b0, rsp_found_index_ff} < limit_ff && !rsp_bit_value_ff)
      else $error("allocated index past the search limit");

   // the bitmap is never written while idle
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == bfa_pkg::ST_IDLE |-> !ram_wr_en)
      else $error("bitmap write while idle");

endmodule

FILE: rtl/core/bfa_ram.sv
`timescale 1ns / 1ps

module bfa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sim/tb_bitmap_first_free_allocator.sv
`timescale 1ns / 1ps

module tb_bitmap_first_free_allocator;

   // run limits
   localparam int STALL_LIMIT    = 8000;
   localparam int DRAIN_CYCLES   = 1100;
   localparam int INDEX_SPAN     = 1 << bfa_pkg::INDEX_W;
   localparam int RANDOM_PHASES  = 12;
   localparam int PHASE_REQUESTS = 48;

   // operation code 3 is decoded as a test
   localparam logic [bfa_pkg::OP_W-1:0] OP_TEST_ALT = 2'd3;

   typedef struct packed {
      logic [bfa_pkg::OP_W-1:0]    operation;
      logic [bfa_pkg::INDEX_W-1:0] entry_index;
   } bitmap_request_type;

   typedef struct packed {
      logic                         success;
      logic [bfa_pkg::INDEX_W-1:0]  found_index;
      logic [bfa_pkg::OFFSET_W-1:0] absolute_number;
      logic                         bit_value;
   } alloc_outcome_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic [bfa_pkg::OP_W-1:0]     req_operation = '0;
   logic [bfa_pkg::INDEX_W-1:0]  req_entry_index = '0;
   logic                         rsp_strobe;
   logic                         rsp_success;
   logic [bfa_pkg::INDEX_W-1:0]  rsp_found_index;
   logic [bfa_pkg::OFFSET_W-1:0] rsp_absolute_number;
   logic                         rsp_bit_value;
   logic                         psel = 1'b0;
   logic                         penable = 1'b0;
   logic                         pwrite = 1'b0;
   logic [bfa_pkg::CSR_AW-1:0]   paddr = '0;
   logic [bfa_pkg::CSR_DW-1:0]   pwdata = '0;
   logic [bfa_pkg::CSR_DW-1:0]   prdata;
   logic                         pready;

   // shadow of the bitmap and registers
   logic [bfa_pkg::WORD_BITS-1:0] model_bitmap [bfa_pkg::NUM_WORDS];
   logic [bfa_pkg::LIMIT_W-1:0]   model_search_limit;
   logic [bfa_pkg::OFFSET_W-1:0]  model_base_offset;

   bitmap_request_type pending_requests [$];
   alloc_outcome_type  expected_results [$];
   bitmap_request_type next_request;

   int issued_count   = 0;
   int accepted_count = 0;
   int burst_left     = 1;
   int gap_left       = 0;
   int stall_cycles   = 0;
   int error_count    = 0;

   bitmap_first_free_allocator i_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_operation       (req_operation),
      .req_entry_index     (req_entry_index),
      .rsp_strobe          (rsp_strobe),
      .rsp_success         (rsp_success),
      .rsp_found_index     (rsp_found_index),
      .rsp_absolute_number (rsp_absolute_number),
      .rsp_bit_value       (rsp_bit_value),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // lowest clear entry of the shadow bitmap, BITMAP_ENTRIES when full
   function automatic int lowest_free_entry();
      for (int k = 0; k < bfa_pkg::NUM_WORDS; k++) begin
         if (model_bitmap[k] != '1) begin
            for (int b = 0; b < bfa_pkg::WORD_BITS; b++) begin
               if (!model_bitmap[k][b]) return k * bfa_pkg::WORD_BITS + b;
            end
         end
      end
      return bfa_pkg::BITMAP_ENTRIES;
   endfunction

   // result of one request, updating the shadow bitmap
   function automatic alloc_outcome_type predict_outcome(logic [bfa_pkg::OP_W-1:0] op,
                                                         logic [bfa_pkg::INDEX_W-1:0] idx);
      alloc_outcome_type outcome;
      int                limit;
      int                free_idx;
      outcome = '0;
      if (op == bfa_pkg::OP_ALLOC) begin
         limit = int'(model_search_limit);
         if (limit > bfa_pkg::BITMAP_ENTRIES) limit = bfa_pkg::BITMAP_ENTRIES;
         if (limit > INDEX_SPAN) limit = INDEX_SPAN;
         free_idx = lowest_free_entry();
         if (free_idx < limit) begin
            model_bitmap[free_idx / bfa_pkg::WORD_BITS][free_idx % bfa_pkg::WORD_BITS] = 1'b1;
            outcome.success         = 1'b1;
            outcome.found_index     = bfa_pkg::INDEX_W'(free_idx);
            outcome.absolute_number = model_base_offset + bfa_pkg::OFFSET_W'(free_idx);
         end
      end else begin
         outcome.found_index     = idx;
         outcome.absolute_number = model_base_offset + bfa_pkg::OFFSET_W'(idx);
         if (int'(idx) < bfa_pkg::BITMAP_ENTRIES) begin
            outcome.success   = 1'b1;
            outcome.bit_value = model_bitmap[idx / bfa_pkg::WORD_BITS][idx % bfa_pkg::WORD_BITS];
            if (op == bfa_pkg::OP_MARK)
               model_bitmap[idx / bfa_pkg::WORD_BITS][idx % bfa_pkg::WORD_BITS] = 1'b1;
         end
      end
      return outcome;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endfunction

   // request driver: bursts of requests with random gaps
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && issued_count != accepted_count)) begin
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            next_request = pending_requests.pop_front();
            req_operation   <= next_request.operation;
            req_entry_index <= next_request.entry_index;
            start           <= 1'b1;
            issued_count++;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // result check, request acceptance and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result: found_index 0x%0h", rsp_found_index);
               error_count++;
            end else begin
               automatic alloc_outcome_type want = expected_results.pop_front();
               check_field("success", 32'(want.success), 32'(rsp_success));
               check_field("found_index", 32'(want.found_index), 32'(rsp_found_index));
               check_field("absolute_number", want.absolute_number, rsp_absolute_number);
               check_field("bit_value", 32'(want.bit_value), 32'(rsp_bit_value));
            end
         end
         if (start && !busy) begin
            accepted_count++;
            expected_results.push_back(predict_outcome(req_operation, req_entry_index));
         end
      end
      if ((start && !busy) || rsp_strobe || (psel && penable)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("FAIL bitmap_first_free_allocator");
         $finish;
      end
   end

   // register write followed by a read back
   task automatic program_register(logic sel, logic [bfa_pkg::CSR_DW-1:0] value);
      logic [bfa_pkg::CSR_DW-1:0] readback;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {sel, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (sel == bfa_pkg::REG_SEARCH_LIMIT) model_search_limit = value[bfa_pkg::LIMIT_W-1:0];
      else model_base_offset = value[bfa_pkg::OFFSET_W-1:0];
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      psel <= 1'b1;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      readback = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (sel == bfa_pkg::REG_SEARCH_LIMIT)
         check_field("search_limit", 32'(model_search_limit),
                     32'(readback[bfa_pkg::LIMIT_W-1:0]));
      else
         check_field("base_offset", model_base_offset, readback[bfa_pkg::OFFSET_W-1:0]);
   endtask

   task automatic queue_request(logic [bfa_pkg::OP_W-1:0] op, int idx);
      bitmap_request_type req;
      req.operation   = op;
      req.entry_index = bfa_pkg::INDEX_W'(idx);
      pending_requests.push_back(req);
   endtask

   // wait until every request is done and the block is idle
   task automatic wait_idle();
      do @(posedge clock);
      while (pending_requests.size() != 0 || start || expected_results.size() != 0 || busy);
   endtask

   // random requests, mostly around the allocation frontier
   task automatic queue_random_phase(int count);
      int                       frontier;
      int                       idx;
      int                       pick;
      logic [bfa_pkg::OP_W-1:0] op;
      frontier = lowest_free_entry();
      for (int n = 0; n < count; n++) begin
         pick = int'($urandom_range(0, 99));
         if (pick < 45) op = bfa_pkg::OP_ALLOC;
         else if (pick < 70) op = bfa_pkg::OP_MARK;
         else if (pick < 92) op = bfa_pkg::OP_TEST;
         else op = OP_TEST_ALT;
         if ($urandom_range(0, 99) < 60) begin
            idx = frontier + int'($urandom_range(0, 96));
            if (idx >= INDEX_SPAN) idx = INDEX_SPAN - 1;
         end else begin
            idx = int'($urandom_range(0, INDEX_SPAN - 1));
         end
         queue_request(op, idx);
      end
   endtask

   initial begin
      logic [bfa_pkg::CSR_DW-1:0] limit_value;
      logic [bfa_pkg::CSR_DW-1:0] offset_value;
      for (int k = 0; k < bfa_pkg::NUM_WORDS; k++) model_bitmap[k] = '0;
      model_search_limit = bfa_pkg::LIMIT_RESET;
      model_base_offset  = bfa_pkg::OFFSET_RESET;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // directed requests with the reset settings
      queue_request(bfa_pkg::OP_TEST, 0);
      queue_request(bfa_pkg::OP_TEST, INDEX_SPAN - 1);
      queue_request(bfa_pkg::OP_ALLOC, 0);
      queue_request(bfa_pkg::OP_ALLOC, INDEX_SPAN - 1);
      queue_request(bfa_pkg::OP_MARK, 2);
      queue_request(bfa_pkg::OP_MARK, 2);
      queue_request(bfa_pkg::OP_ALLOC, 0);
      queue_request(bfa_pkg::OP_TEST, 2);
      queue_request(OP_TEST_ALT, 3);
      queue_request(bfa_pkg::OP_MARK, INDEX_SPAN - 1);
      queue_request(bfa_pkg::OP_TEST, INDEX_SPAN - 1);
      queue_request(bfa_pkg::OP_MARK, 32);
      queue_request(bfa_pkg::OP_TEST, 31);
      queue_request(bfa_pkg::OP_MARK, 21845);
      queue_request(bfa_pkg::OP_MARK, 10922);
      queue_request(bfa_pkg::OP_TEST, 16384);
      queue_request(bfa_pkg::OP_ALLOC, 21845);
      queue_request(OP_TEST_ALT, 21845);
      queue_request(bfa_pkg::OP_MARK, 0);
      wait_idle();

      // settings: extremes first, then limits near the frontier, with one fully random phase
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin
               limit_value  = 32'd0;
               offset_value = 32'hFFFF_FFFF;
            end
            1: begin
               limit_value  = 32'hFFFF_FFFF;
               offset_value = 32'h8000_0000;
            end
            2: begin
               limit_value  = 32'd1;
               offset_value = 32'd0;
            end
            3: begin
               limit_value  = 32'd32768;
               offset_value = 32'hFFFF_F000;
            end
            7: begin
               limit_value  = $urandom_range(0, 65535);
               offset_value = $urandom;
            end
            default: begin
               limit_value  = 32'(lowest_free_entry()) + $urandom_range(0, 48);
               offset_value = $urandom;
            end
         endcase
         program_register(bfa_pkg::REG_SEARCH_LIMIT, limit_value);
         program_register(bfa_pkg::REG_BASE_OFFSET, offset_value);
         queue_random_phase(PHASE_REQUESTS);
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d expected results never arrived", expected_results.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("PASS bitmap_first_free_allocator");
      end else begin
         $display("FAIL bitmap_first_free_allocator");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/bfa_pkg.sv
rtl/core/bfa_ram.sv
rtl/core/bitmap_first_free_allocator.sv
sim/tb_bitmap_first_free_allocator.sv
